// ===== rtl/ille_pkg.sv =====
// Shared types, codes and command/status bundles of the indexed linked list engine.
package ille_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_ERASE  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  position;
        logic [31:0] word_in;
    } req_t;

    typedef struct packed {
        logic [31:0] word_out;
        logic [1:0]  status;
        logic [7:0]  count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_RD_AFTER,
        S_RD_FREE,
        S_INS_W1,
        S_INS_W2,
        S_INS_W3,
        S_ERS_RD,
        S_ERS_UNLINK,
        S_ERS_RD_FP,
        S_ERS_LINK_NEXT,
        S_ERS_LINK_PREV,
        S_READ_ELEM,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD_REQ,
        OP_CHECK,
        OP_WALK,
        OP_RD_SLOT,
        OP_RD_FREE,
        OP_INS_UNLINK_FREE,
        OP_INS_LINK_AFTER,
        OP_INS_LINK_BEFORE,
        OP_ERS_UNLINK,
        OP_ERS_RD_FP,
        OP_ERS_LINK_NEXT,
        OP_ERS_LINK_PREV,
        OP_LOAD_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   link_rd;
        logic   elem_rd;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic is_insert;
        logic is_erase;
        logic head_insert;
        logic walk_last;
        logic clear_last;
    } sts_t;

endpackage

// ===== rtl/ille_ctrl.sv =====
// Sequencer of the list engine: handshakes, request flow and datapath commands.
module ille_ctrl
    import ille_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_room;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_room  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.err)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.head_insert)
                begin
                    state_next = S_RD_AFTER;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.walk_last)
                begin
                    if (sts.is_insert)
                    begin
                        state_next = S_RD_AFTER;
                    end
                    else if (sts.is_erase)
                    begin
                        state_next = S_ERS_RD;
                    end
                    else
                    begin
                        state_next = S_READ_ELEM;
                    end
                end
            end
            S_RD_AFTER:      state_next = S_RD_FREE;
            S_RD_FREE:       state_next = S_INS_W1;
            S_INS_W1:        state_next = S_INS_W2;
            S_INS_W2:        state_next = S_INS_W3;
            S_INS_W3:        state_next = S_FINISH;
            S_ERS_RD:        state_next = S_ERS_UNLINK;
            S_ERS_UNLINK:    state_next = S_ERS_RD_FP;
            S_ERS_RD_FP:     state_next = S_ERS_LINK_NEXT;
            S_ERS_LINK_NEXT: state_next = S_ERS_LINK_PREV;
            S_ERS_LINK_PREV: state_next = S_FINISH;
            S_READ_ELEM:     state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:         state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.link_rd = 1'b0;
        cmd.elem_rd = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            S_IDLE:
            begin
                cmd.op = accept ? OP_LOAD_REQ : OP_NONE;
            end
            S_CHECK:
            begin
                cmd.op      = OP_CHECK;
                cmd.link_rd = 1'b1;
            end
            S_WALK:
            begin
                cmd.op      = OP_WALK;
                cmd.link_rd = !sts.walk_last;
            end
            S_RD_AFTER:
            begin
                cmd.op      = OP_RD_SLOT;
                cmd.link_rd = 1'b1;
            end
            S_RD_FREE:
            begin
                cmd.op      = OP_RD_FREE;
                cmd.link_rd = 1'b1;
            end
            S_INS_W1:        cmd.op = OP_INS_UNLINK_FREE;
            S_INS_W2:        cmd.op = OP_INS_LINK_AFTER;
            S_INS_W3:        cmd.op = OP_INS_LINK_BEFORE;
            S_ERS_RD:
            begin
                cmd.op      = OP_RD_SLOT;
                cmd.link_rd = 1'b1;
                cmd.elem_rd = 1'b1;
            end
            S_ERS_UNLINK:    cmd.op = OP_ERS_UNLINK;
            S_ERS_RD_FP:
            begin
                cmd.op      = OP_ERS_RD_FP;
                cmd.link_rd = 1'b1;
            end
            S_ERS_LINK_NEXT: cmd.op = OP_ERS_LINK_NEXT;
            S_ERS_LINK_PREV: cmd.op = OP_ERS_LINK_PREV;
            S_READ_ELEM:
            begin
                cmd.op      = OP_RD_SLOT;
                cmd.elem_rd = 1'b1;
            end
            S_FINISH:
            begin
                cmd.op = out_room ? OP_LOAD_RESULT : OP_NONE;
            end
            default:         cmd.op = OP_NONE;
        endcase
    end

    // set on a new result, drop once the word is taken
    assign out_valid_next = (cmd.op == OP_LOAD_RESULT) || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/ille_dp.sv =====
// Datapath of the list engine: link and element memories, walk counter, checks, result.
module ille_dp
    import ille_pkg::*;
#(
    parameter int SLOTS        = 256,
    parameter int ELEMENT_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req_word,
    output rsp_t rsp_word,
    input  cmd_t cmd,
    output sts_t sts
);

    localparam int IW    = $clog2(SLOTS);
    localparam int CMP_W = ((IW > 8) ? IW : 8) + 1;

    logic [IW-1:0]           next_link_mem [SLOTS];
    logic [IW-1:0]           prev_link_mem [SLOTS];
    logic [ELEMENT_BITS-1:0] elem_mem      [SLOTS];

    logic [IW-1:0]           nxt_rd_reg;
    logic [IW-1:0]           prv_rd_reg;
    logic [ELEMENT_BITS-1:0] elem_rd_reg;

    // control state
    logic [IW-1:0] count_reg;
    logic [IW-1:0] count_next;
    logic [IW-1:0] fh_reg;
    logic [IW-1:0] fh_next;
    logic          free_none_reg;
    logic          free_none_next;
    logic [IW-1:0] clr_reg;
    logic [IW-1:0] clr_next;

    // request and working registers
    req_t          req_reg;
    logic [IW-1:0] slot_reg;
    logic [IW-1:0] after_reg;
    logic [IW-1:0] free_slot_reg;
    logic [IW-1:0] remain_reg;
    logic          dir_reg;
    logic [1:0]    status_reg;
    rsp_t          rsp_reg;

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] tgt_c;
    logic [IW-1:0]    tgt;
    logic [IW:0]      twice_tgt;
    logic             walk_back;
    logic [IW-1:0]    remain_init;
    logic [1:0]       chk_status;
    logic             last_free;
    logic [IW-1:0]    link;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    clr_nxt_val;
    logic [IW-1:0]    clr_prv_val;

    logic          nxt_we;
    logic [IW-1:0] nxt_wa;
    logic [IW-1:0] nxt_wd;
    logic          prv_we;
    logic [IW-1:0] prv_wa;
    logic [IW-1:0] prv_wd;
    logic          elem_we;

    // request checks
    always_comb
    begin
        pos_c = CMP_W'(req_reg.position);
        cnt_c = CMP_W'(count_reg);
        unique case (req_reg.func) inside
            FUNC_INSERT:
            begin
                if (pos_c > cnt_c)
                begin
                    chk_status = STAT_RANGE;
                end
                else if (count_reg == IW'(SLOTS - 1))
                begin
                    chk_status = STAT_FULL;
                end
                else
                begin
                    chk_status = STAT_DONE;
                end
            end
            FUNC_ERASE, FUNC_READ:
            begin
                chk_status = (pos_c >= cnt_c) ? STAT_RANGE : STAT_DONE;
            end
            default:
            begin
                chk_status = STAT_RANGE;
            end
        endcase
    end

    // insert walks to the slot before the position; others to the position itself
    assign tgt_c       = (req_reg.func == FUNC_INSERT) ? pos_c - CMP_W'(1) : pos_c;
    assign tgt         = IW'(tgt_c);
    assign twice_tgt   = {tgt, 1'b0};
    assign walk_back   = twice_tgt > {1'b0, count_reg};
    assign remain_init = walk_back ? count_reg - tgt - IW'(1) : tgt;
    assign last_free   = (count_reg == IW'(SLOTS - 2));
    assign link        = dir_reg ? prv_rd_reg : nxt_rd_reg;

    assign clr_nxt_val = (clr_reg == '0) ? '0 :
                         (clr_reg == IW'(SLOTS - 1)) ? IW'(1) : clr_reg + IW'(1);
    assign clr_prv_val = (clr_reg == '0) ? '0 :
                         (clr_reg == IW'(1)) ? IW'(SLOTS - 1) : clr_reg - IW'(1);

    assign sts.err         = (chk_status != STAT_DONE);
    assign sts.is_insert   = (req_reg.func == FUNC_INSERT);
    assign sts.is_erase    = (req_reg.func == FUNC_ERASE);
    assign sts.head_insert = (req_reg.func == FUNC_INSERT) && (req_reg.position == 8'd0);
    assign sts.walk_last   = (remain_reg == '0);
    assign sts.clear_last  = (clr_reg == IW'(SLOTS - 1));

    always_comb
    begin
        unique case (cmd.op) inside
            OP_CHECK:                   rd_addr = '0;
            OP_WALK:                    rd_addr = link;
            OP_RD_FREE, OP_ERS_RD_FP:   rd_addr = fh_reg;
            default:                    rd_addr = slot_reg;
        endcase
    end

    // link writes and control state updates
    always_comb
    begin
        nxt_we         = 1'b0;
        nxt_wa         = '0;
        nxt_wd         = '0;
        prv_we         = 1'b0;
        prv_wa         = '0;
        prv_wd         = '0;
        elem_we        = 1'b0;
        count_next     = count_reg;
        fh_next        = fh_reg;
        free_none_next = free_none_reg;
        clr_next       = clr_reg;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                nxt_we   = 1'b1;
                nxt_wa   = clr_reg;
                nxt_wd   = clr_nxt_val;
                prv_we   = 1'b1;
                prv_wa   = clr_reg;
                prv_wd   = clr_prv_val;
                clr_next = clr_reg + IW'(1);
            end
            OP_INS_UNLINK_FREE:
            begin
                // take the free head out of the free chain
                if (last_free)
                begin
                    free_none_next = 1'b1;
                end
                else
                begin
                    nxt_we  = 1'b1;
                    nxt_wa  = prv_rd_reg;
                    nxt_wd  = nxt_rd_reg;
                    prv_we  = 1'b1;
                    prv_wa  = nxt_rd_reg;
                    prv_wd  = prv_rd_reg;
                    fh_next = nxt_rd_reg;
                end
            end
            OP_INS_LINK_AFTER:
            begin
                nxt_we  = 1'b1;
                nxt_wa  = free_slot_reg;
                nxt_wd  = after_reg;
                prv_we  = 1'b1;
                prv_wa  = after_reg;
                prv_wd  = free_slot_reg;
                elem_we = 1'b1;
            end
            OP_INS_LINK_BEFORE:
            begin
                nxt_we     = 1'b1;
                nxt_wa     = slot_reg;
                nxt_wd     = free_slot_reg;
                prv_we     = 1'b1;
                prv_wa     = free_slot_reg;
                prv_wd     = slot_reg;
                count_next = count_reg + IW'(1);
            end
            OP_ERS_UNLINK:
            begin
                nxt_we = 1'b1;
                nxt_wa = prv_rd_reg;
                nxt_wd = nxt_rd_reg;
                prv_we = 1'b1;
                prv_wa = nxt_rd_reg;
                prv_wd = prv_rd_reg;
            end
            OP_ERS_LINK_NEXT:
            begin
                nxt_we = 1'b1;
                nxt_wa = slot_reg;
                prv_we = 1'b1;
                if (free_none_reg)
                begin
                    // freed slot becomes a free chain of its own
                    nxt_wd = slot_reg;
                    prv_wa = slot_reg;
                    prv_wd = slot_reg;
                end
                else
                begin
                    nxt_wd = fh_reg;
                    prv_wa = fh_reg;
                    prv_wd = slot_reg;
                end
            end
            OP_ERS_LINK_PREV:
            begin
                if (!free_none_reg)
                begin
                    prv_we = 1'b1;
                    prv_wa = slot_reg;
                    prv_wd = prv_rd_reg;
                    nxt_we = 1'b1;
                    nxt_wa = prv_rd_reg;
                    nxt_wd = slot_reg;
                end
                fh_next        = slot_reg;
                free_none_next = 1'b0;
                count_next     = count_reg - IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            next_link_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prev_link_mem[prv_wa] <= prv_wd;
        end
        if (cmd.link_rd)
        begin
            nxt_rd_reg <= next_link_mem[rd_addr];
            prv_rd_reg <= prev_link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[free_slot_reg] <= ELEMENT_BITS'(req_reg.word_in);
        end
        if (cmd.elem_rd)
        begin
            elem_rd_reg <= elem_mem[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fh_reg        <= IW'(1);
            free_none_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            fh_reg        <= fh_next;
            free_none_reg <= free_none_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD_REQ:
            begin
                req_reg <= req_word;
            end
            OP_CHECK:
            begin
                status_reg <= chk_status;
                slot_reg   <= '0;
                dir_reg    <= walk_back;
                remain_reg <= remain_init;
            end
            OP_WALK:
            begin
                if (remain_reg == '0)
                begin
                    slot_reg <= link;
                end
                else
                begin
                    remain_reg <= remain_reg - IW'(1);
                end
            end
            OP_RD_FREE:
            begin
                after_reg     <= nxt_rd_reg;
                free_slot_reg <= fh_reg;
            end
            OP_LOAD_RESULT:
            begin
                rsp_reg.word_out <= ((status_reg == STAT_DONE) && (req_reg.func != FUNC_INSERT))
                                    ? 32'(elem_rd_reg) : 32'd0;
                rsp_reg.status   <= status_reg;
                rsp_reg.count    <= 8'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_word = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD_RESULT) |-> (free_none_reg == (count_reg == IW'(SLOTS - 1))))
        else $error("free chain empty flag disagrees with element count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WALK && remain_reg == '0) |=> (slot_reg != '0))
        else $error("walk ended on the sentinel slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CLEAR) |-> (count_reg == '0 && !free_none_reg))
        else $error("list state changed during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RD_FREE) |-> !free_none_reg)
        else $error("insert reached the free chain with no free slot");

endmodule

// ===== rtl/indexed_linked_list_engine.sv =====
// Top level of the indexed linked list engine: sequencer plus datapath.
//
// Positional list of up to SLOTS-1 words kept in a slot store with prev/next link
// memories and a free chain. Each request word inserts, erases or reads at a list
// position and returns exactly one result word with the erased or read element, a
// status and the element count afterwards. One request is in work at a time. A
// request is checked first and then, unless it inserts at the head, walks a distance
// of k links where k is the distance from the nearer end of the list (at most about
// count/2), then does the link updates for an insert or erase or the element read
// for a read. The walk is set by one link memory read per cycle, each address coming
// from the previous read. After reset a clearing pass over all SLOTS slots builds
// the free chain; no request is taken until it ends. A new request is taken while
// the previous result word still waits on the output register.
module indexed_linked_list_engine
    import ille_pkg::*;
#(
    parameter int SLOTS        = 256,
    parameter int ELEMENT_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_word,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_word
);

    cmd_t cmd;
    sts_t sts;

    ille_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ille_dp #(
        .SLOTS        (SLOTS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_word (req_word),
        .rsp_word (rsp_word),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
